// File: hdl/hs_pkg.sv
// hs_pkg: shared types and constants of the heap sorter
// controller states, datapath operations and the status bundle
// no dependencies
package hs_pkg;

   localparam int DEPTH_DEF = 64;
   localparam int VALUE_W   = 32;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_BUILD,
      ST_BLD_CAP,
      ST_SIFT,
      ST_CAP_L,
      ST_CAP_R,
      ST_CMP,
      ST_NEXT,
      ST_EXT,
      ST_EXT_R1,
      ST_EXT_R2,
      ST_OUT_RD,
      ST_OUT_LD
   } hs_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_BUILD_RD,
      OP_BUILD_CAP,
      OP_SIFT,
      OP_CAP_LEFT,
      OP_CAP_RIGHT,
      OP_CMP,
      OP_BUILD_NEXT,
      OP_EXT_RD1,
      OP_EXT_RD2,
      OP_EXT_SWAP,
      OP_OUT_START,
      OP_OUT_RD,
      OP_OUT_LOAD
   } hs_op_type;

   typedef struct packed {
      logic last_item;
      logic left_gt_size;
      logic right_le_size;
      logic child_gt_x;
      logic bidx_zero;
      logic ext_le_one;
      logic out_last;
      logic slot_free;
   } hs_status_type;

endpackage

// File: hdl/hs_ctrl.sv
// hs_ctrl: sequencer of the heap sorter (load, build, extract, output)
// depends on hs_pkg; drives one datapath operation per cycle
module hs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  hs_pkg::hs_status_type status,
   output hs_pkg::hs_op_type     op
);
   import hs_pkg::*;

   hs_state_type state_ff, state_in;
   logic         phase_build_ff, phase_build_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_LOAD;
         phase_build_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         phase_build_ff <= phase_build_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      phase_build_in = phase_build_ff;
      op             = OP_NONE;
      req_ready      = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op = OP_LOAD;
               if (status.last_item) begin
                  phase_build_in = 1'b1;
                  state_in       = ST_BUILD;
               end
            end
         end
         ST_BUILD: begin
            if (status.bidx_zero) begin
               phase_build_in = 1'b0;
               state_in       = ST_EXT;
            end else begin
               op       = OP_BUILD_RD;
               state_in = ST_BLD_CAP;
            end
         end
         ST_BLD_CAP: begin
            op       = OP_BUILD_CAP;
            state_in = ST_SIFT;
         end
         ST_SIFT: begin
            op       = OP_SIFT;
            state_in = status.left_gt_size ? ST_NEXT : ST_CAP_L;
         end
         ST_CAP_L: begin
            op       = OP_CAP_LEFT;
            state_in = status.right_le_size ? ST_CAP_R : ST_CMP;
         end
         ST_CAP_R: begin
            op       = OP_CAP_RIGHT;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            op       = OP_CMP;
            state_in = status.child_gt_x ? ST_SIFT : ST_NEXT;
         end
         ST_NEXT: begin
            if (phase_build_ff) begin
               op       = OP_BUILD_NEXT;
               state_in = ST_BUILD;
            end else begin
               state_in = ST_EXT;
            end
         end
         ST_EXT: begin
            if (status.ext_le_one) begin
               op       = OP_OUT_START;
               state_in = ST_OUT_RD;
            end else begin
               op       = OP_EXT_RD1;
               state_in = ST_EXT_R1;
            end
         end
         ST_EXT_R1: begin
            op       = OP_EXT_RD2;
            state_in = ST_EXT_R2;
         end
         ST_EXT_R2: begin
            op       = OP_EXT_SWAP;
            state_in = ST_SIFT;
         end
         ST_OUT_RD: begin
            op       = OP_OUT_RD;
            state_in = ST_OUT_LD;
         end
         ST_OUT_LD: begin
            if (status.slot_free) begin
               op       = OP_OUT_LOAD;
               state_in = status.out_last ? ST_LOAD : ST_OUT_RD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule

// File: hdl/hs_dp.sv
// hs_dp: heap store, index registers, compare logic and result register
// depends on hs_pkg; steered by hs_ctrl through one operation per cycle
module hs_dp #(
   parameter int DEPTH = hs_pkg::DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  hs_pkg::hs_op_type                   op,
   output hs_pkg::hs_status_type               status,
   input  logic signed [hs_pkg::VALUE_W-1:0]   req_value,
   input  logic                                req_is_last,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [hs_pkg::VALUE_W-1:0]   rsp_sorted_value,
   output logic                                rsp_end_of_set,
   output logic                                rsp_dropped
);
   import hs_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);

   logic signed [VALUE_W-1:0] heap_store_ff [DEPTH];
   logic signed [VALUE_W-1:0] rd_data_ff;

   logic [CW-1:0] count_ff, count_in, size_ff, size_in, pos_ff, pos_in;
   logic [CW-1:0] bidx_ff, bidx_in, ext_ff, ext_in, cpos_ff, cpos_in, oidx_ff, oidx_in;
   logic signed [VALUE_W-1:0] x_ff, x_in, child_ff, child_in, rsp_value_ff, rsp_value_in;
   logic ovf_ff, ovf_in, rsp_valid_ff, rsp_valid_in;
   logic rsp_end_ff, rsp_end_in, rsp_drop_ff, rsp_drop_in;

   logic [CW:0]               left_w, right_w;
   logic [CW-1:0]             n_w;
   logic                      room_w;
   logic                      we_w, re_w;
   logic [AW-1:0]             wa_w, ra_w;
   logic signed [VALUE_W-1:0] wd_w;

   // one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (we_w) begin
         heap_store_ff[wa_w] <= wd_w;
      end
      if (re_w) begin
         rd_data_ff <= heap_store_ff[ra_w];
      end
   end

   assign left_w  = {pos_ff, 1'b0};
   assign right_w = {pos_ff, 1'b1};
   assign room_w  = count_ff < CW'(DEPTH);
   assign n_w     = room_w ? count_ff + CW'(1) : count_ff;

   always_comb begin
      status.last_item     = req_is_last;
      status.left_gt_size  = left_w > {1'b0, size_ff};
      status.right_le_size = right_w <= {1'b0, size_ff};
      status.child_gt_x    = child_ff > x_ff;
      status.bidx_zero     = bidx_ff == '0;
      status.ext_le_one    = ext_ff <= CW'(1);
      status.out_last      = (oidx_ff + CW'(1)) == count_ff;
      status.slot_free     = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      count_in     = count_ff;
      size_in      = size_ff;
      pos_in       = pos_ff;
      bidx_in      = bidx_ff;
      ext_in       = ext_ff;
      cpos_in      = cpos_ff;
      oidx_in      = oidx_ff;
      x_in         = x_ff;
      child_in     = child_ff;
      ovf_in       = ovf_ff;
      rsp_value_in = rsp_value_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_drop_in  = rsp_drop_ff;
      we_w         = 1'b0;
      re_w         = 1'b0;
      wa_w         = '0;
      ra_w         = '0;
      wd_w         = x_ff;
      unique case (op)
         OP_NONE: begin
         end
         OP_LOAD: begin
            if (room_w) begin
               we_w     = 1'b1;
               wa_w     = AW'(count_ff);
               wd_w     = req_value;
               count_in = count_ff + CW'(1);
            end else begin
               ovf_in = 1'b1;
            end
            if (req_is_last) begin
               size_in = n_w;
               bidx_in = n_w >> 1;
               ext_in  = n_w;
            end
         end
         OP_BUILD_RD: begin
            re_w = 1'b1;
            ra_w = AW'(bidx_ff - CW'(1));
         end
         OP_BUILD_CAP: begin
            x_in   = rd_data_ff;
            pos_in = bidx_ff;
         end
         OP_SIFT: begin
            // leaf: the held value settles here
            if (status.left_gt_size) begin
               we_w = 1'b1;
               wa_w = AW'(pos_ff - CW'(1));
               wd_w = x_ff;
            end else begin
               re_w = 1'b1;
               ra_w = AW'(left_w - 1'b1);
            end
         end
         OP_CAP_LEFT: begin
            child_in = rd_data_ff;
            cpos_in  = CW'(left_w);
            if (status.right_le_size) begin
               re_w = 1'b1;
               ra_w = AW'(left_w);
            end
         end
         OP_CAP_RIGHT: begin
            if (rd_data_ff > child_ff) begin
               child_in = rd_data_ff;
               cpos_in  = CW'(right_w);
            end
         end
         OP_CMP: begin
            we_w = 1'b1;
            wa_w = AW'(pos_ff - CW'(1));
            if (status.child_gt_x) begin
               wd_w   = child_ff;
               pos_in = cpos_ff;
            end else begin
               wd_w = x_ff;
            end
         end
         OP_BUILD_NEXT: begin
            bidx_in = bidx_ff - CW'(1);
         end
         OP_EXT_RD1: begin
            re_w = 1'b1;
            ra_w = '0;
         end
         OP_EXT_RD2: begin
            child_in = rd_data_ff;
            re_w     = 1'b1;
            ra_w     = AW'(ext_ff - CW'(1));
         end
         OP_EXT_SWAP: begin
            // root goes to the heap end, old end value sifts from the root
            x_in    = rd_data_ff;
            we_w    = 1'b1;
            wa_w    = AW'(ext_ff - CW'(1));
            wd_w    = child_ff;
            size_in = ext_ff - CW'(1);
            ext_in  = ext_ff - CW'(1);
            pos_in  = CW'(1);
         end
         OP_OUT_START: begin
            oidx_in = '0;
         end
         OP_OUT_RD: begin
            re_w = 1'b1;
            ra_w = AW'(oidx_ff);
         end
         OP_OUT_LOAD: begin
            rsp_value_in = rd_data_ff;
            rsp_end_in   = status.out_last;
            rsp_drop_in  = ovf_ff;
            oidx_in      = oidx_ff + CW'(1);
            if (status.out_last) begin
               count_in = '0;
               ovf_in   = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (op == OP_OUT_LOAD) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      size_ff      <= size_in;
      pos_ff       <= pos_in;
      bidx_ff      <= bidx_in;
      ext_ff       <= ext_in;
      cpos_ff      <= cpos_in;
      oidx_ff      <= oidx_in;
      x_ff         <= x_in;
      child_ff     <= child_in;
      rsp_value_ff <= rsp_value_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_drop_ff  <= rsp_drop_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_end_of_set   = rsp_end_ff;
   assign rsp_dropped      = rsp_drop_ff;

endmodule

// File: hdl/heap_sorter.sv
// heap_sorter: collects a set of signed values and returns it in ascending order
// load takes one item per cycle; sorting starts after the item marked last
// heapsort on one store with one write port and one registered read port; a sift level
// issues the left read, takes left and reads right, takes right, then compares and writes
// (right only if it exists); each result is then read out and waits for a free result slot
// synchronous active-high reset returns to load with an empty set, no flush
module heap_sorter #(
   parameter int DEPTH = hs_pkg::DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // item channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [hs_pkg::VALUE_W-1:0] req_value,
   input  logic                              req_is_last,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [hs_pkg::VALUE_W-1:0] rsp_sorted_value,
   output logic                              rsp_end_of_set,
   output logic                              rsp_dropped
);
   import hs_pkg::*;

   // operation chosen by the sequencer each cycle
   hs_op_type     op;
   // flags the sequencer branches on
   hs_status_type status;

   hs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .op        (op)
   );

   // items past DEPTH are discarded and flagged on every result of the set
   hs_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .op               (op),
      .status           (status),
      .req_value        (req_value),
      .req_is_last      (req_is_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_end_of_set   (rsp_end_of_set),
      .rsp_dropped      (rsp_dropped)
   );

endmodule

// File: bench/heap_sorter_check.sv
`timescale 1ns / 1ps
// heap_sorter_check: watches both channels of the heap sorter, puts each set into ascending order
// and compares every result item with it, field by field
// depends on hs_pkg for the value width and the default depth
module heap_sorter_check #(
   parameter int DEPTH = hs_pkg::DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic signed [hs_pkg::VALUE_W-1:0] req_value,
   input  logic                              req_is_last,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic signed [hs_pkg::VALUE_W-1:0] rsp_sorted_value,
   input  logic                              rsp_end_of_set,
   input  logic                              rsp_dropped,
   output int                                fail_count,
   output int                                results_due
);
   import hs_pkg::*;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef struct packed {
      value_type value;
      logic      end_of_set;
      logic      dropped;
   } sorted_item_type;

   // the set so far, kept in ascending order as it arrives
   value_type       set_store [DEPTH];
   int              set_count = 0;
   logic            set_overflow = 1'b0;
   sorted_item_type sorted_q [$];
   int              mismatches = 0;

   task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                  input logic [VALUE_W-1:0] wanted);
      mismatches++;
      $display("%0t: %s mismatch, got %0h, wanted %0h", $realtime, what, got, wanted);
   endtask

   // insertion into the ordered store; the item marked last closes the set
   task automatic take_value(input value_type v, input logic last);
      int              pos;
      sorted_item_type item;
      if (set_count < DEPTH) begin
         pos = set_count;
         while (pos > 0 && set_store[pos-1] > v) begin
            set_store[pos] = set_store[pos-1];
            pos--;
         end
         set_store[pos] = v;
         set_count++;
      end else begin
         set_overflow = 1'b1;
      end
      if (last) begin
         for (int i = 0; i < set_count; i++) begin
            item.value      = set_store[i];
            item.end_of_set = (i == set_count - 1);
            item.dropped    = set_overflow;
            sorted_q.push_back(item);
         end
         set_count    = 0;
         set_overflow = 1'b0;
      end
   endtask

   task automatic check_result();
      sorted_item_type wanted;
      if (sorted_q.size() == 0) begin
         report_mismatch("unexpected result", rsp_sorted_value, '0);
      end else begin
         wanted = sorted_q.pop_front();
         if (rsp_sorted_value !== wanted.value)
            report_mismatch("sorted_value", rsp_sorted_value, wanted.value);
         if (rsp_end_of_set !== wanted.end_of_set)
            report_mismatch("end_of_set", VALUE_W'(rsp_end_of_set),
                            VALUE_W'(wanted.end_of_set));
         if (rsp_dropped !== wanted.dropped)
            report_mismatch("dropped", VALUE_W'(rsp_dropped), VALUE_W'(wanted.dropped));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         set_count    = 0;
         set_overflow = 1'b0;
         sorted_q.delete();
      end else begin
         if (rsp_valid && rsp_ready)
            check_result();
         if (req_valid && req_ready)
            take_value(req_value, req_is_last);
      end
      fail_count  <= mismatches;
      results_due <= sorted_q.size();
   end

endmodule

// File: bench/heap_sorter_test.sv
`timescale 1ns / 1ps
// heap_sorter_test: top of the heap sorter bench, makes the item stream and gives the verdict
// depends on hs_pkg, heap_sorter and heap_sorter_check
module heap_sorter_test;
   import hs_pkg::*;

   localparam int DEPTH          = DEPTH_DEF;
   localparam int STALL_CYCLES   = 600;     // long receiver hold-off, well past one sort
   localparam int WATCHDOG_LIMIT = 20000;   // well above what a full 64-entry sort needs
   localparam int TAIL_CYCLES    = 200;

   typedef logic signed [VALUE_W-1:0] value_type;

   localparam value_type VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam value_type VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

   logic      clock;
   logic      reset        = 1'b1;
   logic      req_valid    = 1'b0;
   logic      req_ready;
   value_type req_value    = '0;
   logic      req_is_last  = 1'b0;
   logic      rsp_valid;
   logic      rsp_ready    = 1'b0;
   value_type rsp_sorted_value;
   logic      rsp_end_of_set;
   logic      rsp_dropped;
   int        fail_count;
   int        results_due;

   // idling odds in percent, sender side read only by the stimulus process
   int        tx_idle_pct  = 0;
   int        rx_idle_pct  = 0;
   // the stimulus flips stall_go to ask the receiver for one long hold-off
   logic      stall_go     = 1'b0;
   logic      stall_seen   = 1'b0;
   int        stall_left   = 0;
   int        quiet_cycles = 0;
   int        items_sent   = 0;

   heap_sorter u_dut (.*);

   heap_sorter_check #(.DEPTH(DEPTH)) u_check (.*);

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // receiver: random ready, or a counted hold-off when one is asked for
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
         stall_seen <= 1'b0;
      end else if (stall_go != stall_seen) begin
         stall_seen <= stall_go;
         stall_left <= STALL_CYCLES;
         rsp_ready  <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // watchdog: too long with no item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // offer one item, with random idle cycles in front of it
   // ready is looked at on the falling edge, where nothing is changing
   task automatic send_item(input value_type v, input logic last);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_value   <= v;
      req_is_last <= last;
      @(negedge clock);
      while (!req_ready)
         @(negedge clock);
      @(posedge clock);
      items_sent++;
   endtask

   // extremes, a tight band around zero for plenty of equal values, and full range
   function automatic value_type rand_value();
      unique case ($urandom_range(9))
         0:       return VALUE_MIN;
         1:       return VALUE_MAX;
         2, 3:    return value_type'(int'($urandom_range(8)) - 4);
         default: return value_type'($urandom);
      endcase
   endfunction

   // mostly short sets so that sorting stays quick, now and then a long one
   function automatic int rand_set_size();
      int pick;
      pick = $urandom_range(99);
      if (pick < 85)
         return $urandom_range(12, 1);
      else if (pick < 95)
         return $urandom_range(40, 13);
      else
         return $urandom_range(70, 60);
   endfunction

   task automatic send_set(input int size);
      for (int i = 0; i < size; i++)
         send_item(rand_value(), i == size - 1);
   endtask

   // stop offering and hold the sender until every predicted result item has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0)
         @(posedge clock);
   endtask

   // one idling setting: an opening set of the given size, then random sets
   task automatic run_phase(input int tx_pct, input int rx_pct, input int budget,
                            input int opening_size);
      int first;
      first       = items_sent;
      tx_idle_pct = tx_pct;
      rx_idle_pct <= rx_pct;
      send_set(opening_size);
      while (items_sent - first < budget)
         send_set(rand_set_size());
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      tx_idle_pct = 17;
      rx_idle_pct <= 77;

      // single-item sets at both extremes
      send_item(VALUE_MIN, 1'b1);
      send_item(VALUE_MAX, 1'b1);
      // extremes mixed with values round zero, each extreme twice
      send_item(VALUE_MAX, 1'b0);
      send_item(VALUE_MIN, 1'b0);
      send_item(value_type'(0), 1'b0);
      send_item(value_type'(-1), 1'b0);
      send_item(value_type'(1), 1'b0);
      send_item(VALUE_MAX, 1'b0);
      send_item(VALUE_MIN, 1'b0);
      send_item(value_type'(0), 1'b1);
      // all equal
      send_item(value_type'(5), 1'b0);
      send_item(value_type'(5), 1'b0);
      send_item(value_type'(5), 1'b1);
      // arriving in descending order
      send_item(value_type'(3), 1'b0);
      send_item(value_type'(2), 1'b0);
      send_item(value_type'(1), 1'b0);
      send_item(value_type'(0), 1'b0);
      send_item(value_type'(-1), 1'b1);
      // alternating bit patterns
      send_item(value_type'(32'h5555_5555), 1'b0);
      send_item(value_type'(32'haaaa_aaaa), 1'b1);

      // slow sender, slower receiver; opens with an overfull set, items past DEPTH dropped
      run_phase(17, 77, 145, $urandom_range(70, 65));
      // the other way round; opens with a set that fills the store exactly
      run_phase(77, 17, 145, DEPTH);

      // pause until everything is back, then hold the receiver off while the
      // sender keeps going, so the block fills up and stops taking items
      drain_results();
      tx_idle_pct = 0;
      rx_idle_pct <= 0;
      stall_go    <= ~stall_go;
      send_set(10);
      send_set(10);
      send_set(4);

      // no idling on either side
      run_phase(0, 0, 120, $urandom_range(70, 65));

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// File: heap_sorter.f
hdl/hs_pkg.sv
hdl/hs_ctrl.sv
hdl/hs_dp.sv
hdl/heap_sorter.sv
bench/heap_sorter_check.sv
bench/heap_sorter_test.sv
